// ===== src/rrts_pkg.sv =====
package rrts_pkg;

    localparam int NUM_SLOTS_DEF = 32;

    // APB side: one 32-bit register, word index in paddr[2]
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_TIMESLICE = 1'b0;
    localparam logic [7:0] TIMESLICE_RST = 8'd4;

    // operation codes
    localparam logic [1:0] OP_SPAWN = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_REAP  = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // task states
    localparam logic [2:0] TS_UNUSED  = 3'd0;
    localparam logic [2:0] TS_READY   = 3'd1;
    localparam logic [2:0] TS_RUNNING = 3'd2;
    localparam logic [2:0] TS_BLOCKED = 3'd3;
    localparam logic [2:0] TS_ZOMBIE  = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    // datapath actions issued by the controller
    localparam logic [4:0] A_NOP        = 5'd0;
    localparam logic [4:0] A_LOAD       = 5'd1;
    localparam logic [4:0] A_SCAN_FREE  = 5'd2;
    localparam logic [4:0] A_SCAN_PID   = 5'd3;
    localparam logic [4:0] A_SCAN_ZERO  = 5'd4;
    localparam logic [4:0] A_SCAN_READY = 5'd5;
    localparam logic [4:0] A_SCAN       = 5'd6;
    localparam logic [4:0] A_READ_CUR   = 5'd7;
    localparam logic [4:0] A_TAKE_CUR   = 5'd8;
    localparam logic [4:0] A_CHARGE     = 5'd9;
    localparam logic [4:0] A_SPAWN_WR   = 5'd10;
    localparam logic [4:0] A_FULL       = 5'd11;
    localparam logic [4:0] A_NOT_FOUND  = 5'd12;
    localparam logic [4:0] A_DEMOTE     = 5'd13;
    localparam logic [4:0] A_SET_WR     = 5'd14;
    localparam logic [4:0] A_REAP_WR    = 5'd15;
    localparam logic [4:0] A_FALLBACK   = 5'd16;
    localparam logic [4:0] A_CUR_WR     = 5'd17;
    localparam logic [4:0] A_CUR_READY  = 5'd18;
    localparam logic [4:0] A_SWITCH     = 5'd19;
    localparam logic [4:0] A_RESULT     = 5'd20;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] pid;
        logic [2:0]  new_state;
    } rrts_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  slot;
        logic        current_valid;
        logic [15:0] current_pid;
        logic [31:0] current_runtime;
        logic [5:0]  task_count;
        logic [31:0] switch_count;
        logic        switched;
        logic        demoted_valid;
        logic [15:0] demoted_pid;
    } rrts_out_t;

    typedef struct packed {
        logic [15:0] ident;
        logic [2:0]  state;
        logic [31:0] ticks;
    } rrts_entry_t;

    typedef struct packed {
        logic [4:0] act;
    } rrts_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       cur_valid;
        logic       found;
        logic       cur_is_hit;
        logic       ns_running;
        logic       ce_running;
        logic       switch_due;
        logic       scan_done;
    } rrts_sts_t;

endpackage

// ===== src/rrts_ram.sv =====
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/rrts_dp.sv =====
module rrts_dp import rrts_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  rrts_in_t  s_data,
    input  logic [7:0] timeslice,
    input  rrts_cmd_t cmd,
    output rrts_sts_t sts,
    output rrts_out_t m_data
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int LEFT_W = SLOT_W + 1;
    localparam int ENT_W  = $bits(rrts_entry_t);

    localparam logic [1:0] SCAN_FREE  = 2'd0;
    localparam logic [1:0] SCAN_PID   = 2'd1;
    localparam logic [1:0] SCAN_ZERO  = 2'd2;
    localparam logic [1:0] SCAN_READY = 2'd3;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    // architectural state
    logic                 cur_valid_reg, cur_valid_next;
    logic [SLOT_W-1:0]    cur_slot_reg, cur_slot_next;
    logic [5:0]           used_reg, used_next;
    logic [31:0]          switch_reg, switch_next;
    logic [7:0]           slice_reg, slice_next;
    logic [NUM_SLOTS-1:0] vld_reg, vld_next;

    // item and scratch
    logic [1:0]           op_reg, op_next;
    logic [15:0]          pid_reg, pid_next;
    logic [2:0]           ns_reg, ns_next;
    logic [1:0]           sc_kind_reg, sc_kind_next;
    logic [SLOT_W-1:0]    sc_addr_reg, sc_addr_next;
    logic [LEFT_W-1:0]    sc_left_reg, sc_left_next;
    logic                 rdv_reg, rdv_next;
    logic                 hit_reg, hit_next;
    logic [SLOT_W-1:0]    hit_slot_reg, hit_slot_next;
    rrts_entry_t          hit_ent_reg, hit_ent_next;
    rrts_entry_t          ce_reg, ce_next;
    logic [1:0]           status_reg, status_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 switched_reg, switched_next;
    logic                 dem_valid_reg, dem_valid_next;
    logic [15:0]          dem_pid_reg, dem_pid_next;
    rrts_out_t            res_reg, res_next;
    logic [SLOT_W-1:0]    rd_addr_reg;
    logic                 rd_vld_reg;

    // table memory
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    rrts_entry_t          ram_wdata;
    logic                 ram_re;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [ENT_W-1:0]     ram_rdata;

    rrts_entry_t          rd_ent;
    logic                 kind_hit;
    logic                 match;
    logic [SLOT_W-1:0]    cur_inc;
    logic [SLOT_W-1:0]    sc_inc;
    logic [SLOT_W-1:0]    res_slot;
    logic [SLOT_W+4:0]    res_slot_wide;

    rrts_ram #(
        .WIDTH(ENT_W),
        .DEPTH(NUM_SLOTS)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // an entry never written reads as its reset value
    always_comb begin
        if (rd_vld_reg) begin
            rd_ent = rrts_entry_t'(ram_rdata);
        end else begin
            rd_ent.ident = '0;
            rd_ent.state = (rd_addr_reg == '0) ? TS_RUNNING : TS_UNUSED;
            rd_ent.ticks = '0;
        end
    end

    always_comb begin
        unique case (sc_kind_reg)
            SCAN_FREE:  kind_hit = (rd_ent.state == TS_UNUSED) || (rd_ent.state == TS_ZOMBIE);
            SCAN_PID:   kind_hit = (rd_ent.state != TS_UNUSED) && (rd_ent.ident == pid_reg);
            SCAN_ZERO:  kind_hit = (rd_ent.state != TS_UNUSED) && (rd_ent.ident == '0);
            SCAN_READY: kind_hit = (rd_ent.state == TS_READY);
            default:    kind_hit = 1'b0;
        endcase
    end

    assign match   = rdv_reg && kind_hit;
    assign cur_inc = (cur_slot_reg == LAST_SLOT) ? '0 : cur_slot_reg + SLOT_W'(1);
    assign sc_inc  = (sc_addr_reg == LAST_SLOT) ? '0 : sc_addr_reg + SLOT_W'(1);

    assign ram_re    = ((cmd.act == A_SCAN) && (sc_left_reg != '0)) || (cmd.act == A_READ_CUR);
    assign ram_raddr = (cmd.act == A_READ_CUR) ? cur_slot_reg : sc_addr_reg;

    // write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = hit_slot_reg;
        ram_wdata = hit_ent_reg;
        case (cmd.act)
            A_SPAWN_WR: begin
                ram_we          = 1'b1;
                ram_wdata.ident = pid_reg;
                ram_wdata.state = TS_READY;
                ram_wdata.ticks = '0;
            end
            A_SET_WR: begin
                ram_we          = (ns_reg <= TS_ZOMBIE);
                ram_wdata.state = ns_reg;
            end
            A_REAP_WR: begin
                ram_we          = 1'b1;
                ram_wdata.ident = '0;
                ram_wdata.state = TS_UNUSED;
                ram_wdata.ticks = '0;
            end
            A_FALLBACK: begin
                ram_we          = hit_reg;
                ram_wdata.state = TS_RUNNING;
            end
            A_SWITCH: begin
                ram_we          = 1'b1;
                ram_wdata.state = TS_RUNNING;
            end
            A_CUR_WR: begin
                ram_we    = 1'b1;
                ram_waddr = cur_slot_reg;
                ram_wdata = ce_reg;
            end
            A_CUR_READY, A_DEMOTE: begin
                ram_we          = 1'b1;
                ram_waddr       = cur_slot_reg;
                ram_wdata       = ce_reg;
                ram_wdata.state = TS_READY;
            end
            default: ;
        endcase
    end

    assign res_slot      = ((op_reg == OP_TICK) && cur_valid_reg) ? cur_slot_reg :
                           (op_reg == OP_TICK) ? '0 : slot_reg;
    assign res_slot_wide = {5'b0, res_slot};

    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_slot_next  = cur_slot_reg;
        used_next      = used_reg;
        switch_next    = switch_reg;
        slice_next     = slice_reg;
        vld_next       = vld_reg;
        op_next        = op_reg;
        pid_next       = pid_reg;
        ns_next        = ns_reg;
        sc_kind_next   = sc_kind_reg;
        sc_addr_next   = sc_addr_reg;
        sc_left_next   = sc_left_reg;
        rdv_next       = 1'b0;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        hit_ent_next   = hit_ent_reg;
        ce_next        = ce_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        switched_next  = switched_reg;
        dem_valid_next = dem_valid_reg;
        dem_pid_next   = dem_pid_reg;
        res_next       = res_reg;

        if (ram_we) begin
            vld_next[ram_waddr] = 1'b1;
        end

        unique case (cmd.act)
            A_LOAD: begin
                op_next        = s_data.opcode;
                pid_next       = s_data.pid;
                ns_next        = s_data.new_state;
                status_next    = STAT_OK;
                slot_next      = '0;
                switched_next  = 1'b0;
                dem_valid_next = 1'b0;
                dem_pid_next   = '0;
            end
            A_SCAN_FREE, A_SCAN_PID, A_SCAN_ZERO: begin
                sc_kind_next = (cmd.act == A_SCAN_FREE) ? SCAN_FREE :
                               (cmd.act == A_SCAN_PID)  ? SCAN_PID : SCAN_ZERO;
                sc_addr_next = '0;
                sc_left_next = LEFT_W'(NUM_SLOTS);
                hit_next     = 1'b0;
            end
            A_SCAN_READY: begin
                sc_kind_next = SCAN_READY;
                sc_addr_next = cur_inc;
                sc_left_next = LEFT_W'(NUM_SLOTS - 1);
                hit_next     = 1'b0;
            end
            A_SCAN: begin
                if (sc_left_reg != '0) begin
                    sc_addr_next = sc_inc;
                    sc_left_next = sc_left_reg - LEFT_W'(1);
                    rdv_next     = 1'b1;
                end
                if (match) begin
                    hit_next      = 1'b1;
                    hit_slot_next = rd_addr_reg;
                    hit_ent_next  = rd_ent;
                end
            end
            A_TAKE_CUR: begin
                ce_next = rd_ent;
            end
            A_CHARGE: begin
                if (ce_reg.state == TS_RUNNING) begin
                    ce_next.ticks = ce_reg.ticks + 32'd1;
                    if (slice_reg != 8'hFF) begin
                        slice_next = slice_reg + 8'd1;
                    end
                end
            end
            A_SPAWN_WR: begin
                slot_next = hit_slot_reg;
                if (used_reg != 6'd63) begin
                    used_next = used_reg + 6'd1;
                end
            end
            A_FULL: begin
                status_next = STAT_FULL;
            end
            A_NOT_FOUND: begin
                status_next = STAT_NOT_FOUND;
            end
            A_DEMOTE: begin
                dem_valid_next = 1'b1;
                dem_pid_next   = ce_reg.ident;
            end
            A_SET_WR: begin
                slot_next = hit_slot_reg;
                if (ns_reg == TS_RUNNING) begin
                    cur_valid_next = 1'b1;
                    cur_slot_next  = hit_slot_reg;
                    slice_next     = '0;
                end
            end
            A_REAP_WR: begin
                slot_next = hit_slot_reg;
                if (used_reg != '0) begin
                    used_next = used_reg - 6'd1;
                end
            end
            A_FALLBACK: begin
                if (hit_reg) begin
                    cur_slot_next = hit_slot_reg;
                    slice_next    = '0;
                end else begin
                    cur_valid_next = 1'b0;
                    cur_slot_next  = '0;
                end
            end
            A_SWITCH: begin
                cur_slot_next = hit_slot_reg;
                slice_next    = '0;
                switch_next   = switch_reg + 32'd1;
                switched_next = 1'b1;
            end
            A_RESULT: begin
                res_next.status          = status_reg;
                res_next.slot            = res_slot_wide[4:0];
                res_next.current_valid   = cur_valid_reg;
                res_next.current_pid     = cur_valid_reg ? rd_ent.ident : '0;
                res_next.current_runtime = cur_valid_reg ? rd_ent.ticks : '0;
                res_next.task_count      = used_reg;
                res_next.switch_count    = switch_reg;
                res_next.switched        = switched_reg;
                res_next.demoted_valid   = dem_valid_reg;
                res_next.demoted_pid     = dem_pid_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b1;
            cur_slot_reg  <= '0;
            used_reg      <= 6'd1;
            switch_reg    <= '0;
            slice_reg     <= '0;
            vld_reg       <= '0;
            rdv_reg       <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            cur_slot_reg  <= cur_slot_next;
            used_reg      <= used_next;
            switch_reg    <= switch_next;
            slice_reg     <= slice_next;
            vld_reg       <= vld_next;
            rdv_reg       <= rdv_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        pid_reg       <= pid_next;
        ns_reg        <= ns_next;
        sc_kind_reg   <= sc_kind_next;
        sc_addr_reg   <= sc_addr_next;
        sc_left_reg   <= sc_left_next;
        hit_reg       <= hit_next;
        hit_slot_reg  <= hit_slot_next;
        hit_ent_reg   <= hit_ent_next;
        ce_reg        <= ce_next;
        status_reg    <= status_next;
        slot_reg      <= slot_next;
        switched_reg  <= switched_next;
        dem_valid_reg <= dem_valid_next;
        dem_pid_reg   <= dem_pid_next;
        res_reg       <= res_next;
        if (ram_re) begin
            rd_addr_reg <= ram_raddr;
            rd_vld_reg  <= vld_reg[ram_raddr];
        end
    end

    assign sts.op         = op_reg;
    assign sts.cur_valid  = cur_valid_reg;
    assign sts.found      = hit_reg;
    assign sts.cur_is_hit = cur_valid_reg && (cur_slot_reg == hit_slot_reg);
    assign sts.ns_running = (ns_reg == TS_RUNNING);
    assign sts.ce_running = (ce_reg.state == TS_RUNNING);
    assign sts.switch_due = (used_reg > 6'd1) && (slice_reg >= timeslice);
    assign sts.scan_done  = match || ((sc_left_reg == '0) && !rdv_reg);

    assign m_data = res_reg;

endmodule

// ===== src/rrts_ctrl.sv =====
module rrts_ctrl import rrts_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  rrts_sts_t sts,
    output rrts_cmd_t cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISPATCH = 5'd1;
    localparam logic [4:0] S_SCAN     = 5'd2;
    localparam logic [4:0] S_SPAWN    = 5'd3;
    localparam logic [4:0] S_SETST    = 5'd4;
    localparam logic [4:0] S_DTAKE    = 5'd5;
    localparam logic [4:0] S_DCHK     = 5'd6;
    localparam logic [4:0] S_SETWR    = 5'd7;
    localparam logic [4:0] S_REAP     = 5'd8;
    localparam logic [4:0] S_ZSCAN    = 5'd9;
    localparam logic [4:0] S_FALLBACK = 5'd10;
    localparam logic [4:0] S_TTAKE    = 5'd11;
    localparam logic [4:0] S_TCHARGE  = 5'd12;
    localparam logic [4:0] S_TDECIDE  = 5'd13;
    localparam logic [4:0] S_TSWITCH  = 5'd14;
    localparam logic [4:0] S_TSWAP    = 5'd15;
    localparam logic [4:0] S_REPORT   = 5'd16;
    localparam logic [4:0] S_RESULT   = 5'd17;

    logic [4:0] state_reg, state_next;
    logic [4:0] ret_reg, ret_next;
    logic       m_valid_reg, m_valid_next;
    logic [4:0] act;

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        act        = A_NOP;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    act        = A_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (sts.op)
                    OP_SPAWN: begin
                        act        = A_SCAN_FREE;
                        ret_next   = S_SPAWN;
                        state_next = S_SCAN;
                    end
                    OP_SET: begin
                        act        = A_SCAN_PID;
                        ret_next   = S_SETST;
                        state_next = S_SCAN;
                    end
                    OP_REAP: begin
                        act        = A_SCAN_PID;
                        ret_next   = S_REAP;
                        state_next = S_SCAN;
                    end
                    OP_TICK: begin
                        if (sts.cur_valid) begin
                            act        = A_READ_CUR;
                            state_next = S_TTAKE;
                        end else begin
                            state_next = S_REPORT;
                        end
                    end
                    default: state_next = S_REPORT;
                endcase
            end
            S_SCAN: begin
                act = A_SCAN;
                if (sts.scan_done) begin
                    state_next = ret_reg;
                end
            end
            S_SPAWN: begin
                act        = sts.found ? A_SPAWN_WR : A_FULL;
                state_next = S_REPORT;
            end
            S_SETST: begin
                if (!sts.found) begin
                    act        = A_NOT_FOUND;
                    state_next = S_REPORT;
                end else if (sts.ns_running && sts.cur_valid && !sts.cur_is_hit) begin
                    act        = A_READ_CUR;
                    state_next = S_DTAKE;
                end else begin
                    act        = A_SET_WR;
                    state_next = S_REPORT;
                end
            end
            S_DTAKE: begin
                act        = A_TAKE_CUR;
                state_next = S_DCHK;
            end
            S_DCHK: begin
                if (sts.ce_running) begin
                    act = A_DEMOTE;
                end
                state_next = S_SETWR;
            end
            S_SETWR: begin
                act        = A_SET_WR;
                state_next = S_REPORT;
            end
            S_REAP: begin
                if (!sts.found) begin
                    act        = A_NOT_FOUND;
                    state_next = S_REPORT;
                end else begin
                    act        = A_REAP_WR;
                    state_next = sts.cur_is_hit ? S_ZSCAN : S_REPORT;
                end
            end
            S_ZSCAN: begin
                act        = A_SCAN_ZERO;
                ret_next   = S_FALLBACK;
                state_next = S_SCAN;
            end
            S_FALLBACK: begin
                act        = A_FALLBACK;
                state_next = S_REPORT;
            end
            S_TTAKE: begin
                act        = A_TAKE_CUR;
                state_next = S_TCHARGE;
            end
            S_TCHARGE: begin
                act        = A_CHARGE;
                state_next = S_TDECIDE;
            end
            S_TDECIDE: begin
                if (sts.switch_due) begin
                    act        = A_SCAN_READY;
                    ret_next   = S_TSWITCH;
                    state_next = S_SCAN;
                end else begin
                    act        = A_CUR_WR;
                    state_next = S_REPORT;
                end
            end
            S_TSWITCH: begin
                if (sts.found) begin
                    act        = A_CUR_READY;
                    state_next = S_TSWAP;
                end else begin
                    act        = A_CUR_WR;
                    state_next = S_REPORT;
                end
            end
            S_TSWAP: begin
                act        = A_SWITCH;
                state_next = S_REPORT;
            end
            S_REPORT: begin
                act        = A_READ_CUR;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    act        = A_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (act == A_RESULT) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign cmd.act = act;

endmodule

// ===== src/round_robin_task_table_scheduler.sv =====
// Round-robin task table scheduler.
// Input channel (s_valid/s_ready/s_data): one operation per transfer: spawn,
// set task state, reap, or timer tick. Result channel (m_valid/m_ready/m_data):
// exactly one result transfer per operation, in order, carrying the status,
// the slot touched and a snapshot of the current task and counters.
// APB port: register 0 (byte address 0) is the time slice in ticks.
// Table access: a sequential scan reads the slot table through its single RAM read
// port, one slot per cycle. Spawn, set state and a tick with a switch scan the
// table once, a reap of the current task scans it twice, and a tick with no
// current task does not scan it at all.
// One operation is in flight at a time; s_ready is high while the controller
// idles, also while the previous result still waits in the output register.
// If the receiver stalls, the finished result holds in the output register and
// the next operation stops just before its own result until that one is taken.
// Reset: slot 0 holds the running task with id 0, all other slots are unused,
// the time slice is 4. The table needs no clearing pass: per-slot valid bits
// clear at once and an unwritten slot reads as its reset value.
module round_robin_task_table_scheduler import rrts_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // operations in
    input  logic               s_valid,
    output logic               s_ready,
    input  rrts_in_t           s_data,
    // results out
    output logic               m_valid,
    input  logic               m_ready,
    output rrts_out_t          m_data
);

    logic [7:0] timeslice_reg, timeslice_next;
    logic       reg_sel;
    rrts_cmd_t  cmd;
    rrts_sts_t  sts;

    // Word index of the register file sits above the byte offset.
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_TIMESLICE);

    // Capture the time slice on the access phase of a write transfer.
    always_comb begin
        timeslice_next = timeslice_reg;
        if (psel && penable && pwrite && reg_sel) begin
            timeslice_next = pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeslice_reg <= TIMESLICE_RST;
        end else begin
            timeslice_reg <= timeslice_next;
        end
    end

    assign prdata = reg_sel ? {{(PDATA_W-8){1'b0}}, timeslice_reg} : '0;
    assign pready = 1'b1;

    // Controller: sequences scans, table writes and the result transfer.
    rrts_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    // Datapath: slot table RAM, scan engine, scheduler state, result register.
    rrts_dp #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .timeslice(timeslice_reg),
        .cmd      (cmd),
        .sts      (sts),
        .m_data   (m_data)
    );

    // One operation at a time: an accepted transfer drops s_ready next cycle.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an operation was in flight");

    // No current task means an empty snapshot.
    a_idle_snapshot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.current_valid |->
            (m_data.current_pid == '0) && (m_data.current_runtime == '0))
        else $error("snapshot of a missing current task is not zero");

    // A switch only comes from a successful tick, never with a demotion.
    a_switch_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.switched |->
            (m_data.status == STAT_OK) && !m_data.demoted_valid)
        else $error("switch flagged on a non-tick result");

    // Demoted id is zero unless a demotion happened.
    a_demote_pid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.demoted_valid |-> (m_data.demoted_pid == '0))
        else $error("demoted id set without a demotion");

endmodule

// ===== bench/tb_round_robin_task_table_scheduler.sv =====
module tb_round_robin_task_table_scheduler;
    import rrts_pkg::*;

    localparam int NSLOT = NUM_SLOTS_DEF;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [PADDR_W-1:0] SLICE_ADDR = {REG_TIMESLICE, 2'b00};

    // operation mixes for the random phases
    localparam int MIX_BALANCED = 0;
    localparam int MIX_FILL     = 1;
    localparam int MIX_CHURN    = 2;
    localparam int MIX_DRAIN    = 3;

    typedef struct packed {
        rrts_in_t  op;
        logic      gold_ok;
        rrts_out_t gold;
    } script_row_t;

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    rrts_in_t           s_data;
    logic               m_valid;
    logic               m_ready;
    rrts_out_t          m_data;

    round_robin_task_table_scheduler u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------
    // Scheduler shadow: task table, current task and counters, updated in
    // transfer order as each operation is accepted.
    // ------------------------------------------------------------------
    logic [15:0] tbl_id [NSLOT];
    logic [2:0]  tbl_st [NSLOT];
    logic [31:0] tbl_rt [NSLOT];
    bit          run_valid;
    int          run_slot;
    logic [5:0]  used_cnt;
    logic [31:0] sw_total;
    logic [7:0]  slice_cnt;
    logic [7:0]  slice_limit;

    // results still owed by the block, oldest first
    rrts_out_t   pending_results[$];
    script_row_t script_rows[$];

    int        miss_cnt;
    int        result_cnt;
    int        cycle_cnt;
    bit        pace_on;
    int        hold_asks;
    int        holds_taken;
    int        stall_left;
    rrts_out_t want;
    string     diff;

    function automatic void sched_reset();
        for (int i = 0; i < NSLOT; i++) begin
            tbl_id[i] = '0;
            tbl_st[i] = TS_UNUSED;
            tbl_rt[i] = '0;
        end
        tbl_st[0]   = TS_RUNNING;
        run_valid   = 1'b1;
        run_slot    = 0;
        used_cnt    = 6'd1;
        sw_total    = '0;
        slice_cnt   = '0;
        slice_limit = TIMESLICE_RST;
    endfunction

    // first non-unused slot carrying this id, -1 when there is none
    function automatic int find_task(logic [15:0] id);
        int hit;
        hit = -1;
        for (int i = NSLOT - 1; i >= 0; i--)
            if (tbl_st[i] != TS_UNUSED && tbl_id[i] == id) hit = i;
        return hit;
    endfunction

    // Apply one operation to the shadow and return the result it must produce.
    function automatic rrts_out_t sched_apply(rrts_in_t op);
        rrts_out_t r;
        int        s;
        int        k;
        int        nx;
        bit        moved;
        r = '0;
        r.status = STAT_OK;
        case (op.opcode)
            OP_SPAWN: begin
                // first unused or zombie slot takes the new task
                s = -1;
                for (int i = NSLOT - 1; i >= 0; i--)
                    if (tbl_st[i] == TS_UNUSED || tbl_st[i] == TS_ZOMBIE) s = i;
                if (s < 0) begin
                    r.status = STAT_FULL;
                end else begin
                    tbl_id[s] = op.pid;
                    tbl_st[s] = TS_READY;
                    tbl_rt[s] = '0;
                    if (used_cnt < 6'd63) used_cnt++;
                    r.slot = s[4:0];
                end
            end
            OP_SET: begin
                s = find_task(op.pid);
                if (s < 0) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    r.slot = s[4:0];
                    // states above zombie leave the table alone
                    if (op.new_state <= TS_ZOMBIE) begin
                        if (op.new_state == TS_RUNNING && run_valid && run_slot != s &&
                            tbl_st[run_slot] == TS_RUNNING) begin
                            tbl_st[run_slot] = TS_READY;
                            r.demoted_valid  = 1'b1;
                            r.demoted_pid    = tbl_id[run_slot];
                        end
                        tbl_st[s] = op.new_state;
                        if (op.new_state == TS_RUNNING) begin
                            run_valid = 1'b1;
                            run_slot  = s;
                            slice_cnt = '0;
                        end
                    end
                end
            end
            OP_REAP: begin
                s = find_task(op.pid);
                if (s < 0) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    r.slot    = s[4:0];
                    tbl_id[s] = '0;
                    tbl_st[s] = TS_UNUSED;
                    tbl_rt[s] = '0;
                    if (used_cnt != 6'd0) used_cnt--;
                    // reaping the current task falls back to the id-0 task
                    if (run_valid && run_slot == s) begin
                        k = find_task(16'h0000);
                        if (k < 0) begin
                            run_valid = 1'b0;
                            run_slot  = 0;
                        end else begin
                            run_slot  = k;
                            tbl_st[k] = TS_RUNNING;
                            slice_cnt = '0;
                        end
                    end
                end
            end
            OP_TICK: begin
                if (run_valid) begin
                    if (tbl_st[run_slot] == TS_RUNNING) begin
                        tbl_rt[run_slot] += 32'd1;
                        if (slice_cnt != 8'hFF) slice_cnt++;
                    end
                    if (used_cnt > 6'd1 && slice_cnt >= slice_limit) begin
                        moved = 1'b0;
                        for (int n = 1; n < NSLOT; n++) begin
                            nx = (run_slot + n) % NSLOT;
                            if (!moved && tbl_st[nx] == TS_READY) begin
                                tbl_st[run_slot] = TS_READY;
                                tbl_st[nx]       = TS_RUNNING;
                                run_slot         = nx;
                                slice_cnt        = '0;
                                sw_total        += 32'd1;
                                moved            = 1'b1;
                            end
                        end
                        r.switched = moved;
                    end
                    r.slot = run_slot[4:0];
                end
            end
        endcase
        r.current_valid   = run_valid;
        r.current_pid     = run_valid ? tbl_id[run_slot] : 16'h0000;
        r.current_runtime = run_valid ? tbl_rt[run_slot] : 32'd0;
        r.task_count      = used_cnt;
        r.switch_count    = sw_total;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic rrts_in_t mk_op(logic [1:0] opc, logic [15:0] pid, logic [2:0] ns);
        rrts_in_t op;
        op.opcode    = opc;
        op.pid       = pid;
        op.new_state = ns;
        return op;
    endfunction

    function automatic rrts_out_t mk_res(logic [1:0] st, logic [4:0] slot, logic cv,
                                         logic [15:0] cpid, logic [31:0] crt,
                                         logic [5:0] tc, logic [31:0] sc, logic swd,
                                         logic dv, logic [15:0] dpid);
        rrts_out_t r;
        r.status          = st;
        r.slot            = slot;
        r.current_valid   = cv;
        r.current_pid     = cpid;
        r.current_runtime = crt;
        r.task_count      = tc;
        r.switch_count    = sc;
        r.switched        = swd;
        r.demoted_valid   = dv;
        r.demoted_pid     = dpid;
        return r;
    endfunction

    function automatic script_row_t plain(logic [1:0] opc, logic [15:0] pid, logic [2:0] ns);
        script_row_t row;
        row.op      = mk_op(opc, pid, ns);
        row.gold_ok = 1'b0;
        row.gold    = '0;
        return row;
    endfunction

    function automatic script_row_t golden(logic [1:0] opc, logic [15:0] pid, logic [2:0] ns,
                                           rrts_out_t res);
        script_row_t row;
        row.op      = mk_op(opc, pid, ns);
        row.gold_ok = 1'b1;
        row.gold    = res;
        return row;
    endfunction

    // Directed walk from reset (slice of 4). Results are typed in only for the
    // first few rows, where the state is trivial; the rest go to the shadow.
    function automatic void load_script();
        // tick after reset charges the id-0 task
        script_rows.push_back(golden(OP_TICK, 16'hFFFF, 3'd7,
            mk_res(STAT_OK, 5'd0, 1'b1, 16'h0, 32'd1, 6'd1, 32'd0, 1'b0, 1'b0, 16'h0)));
        // unknown ids on set state and reap
        script_rows.push_back(golden(OP_SET, 16'h1234, TS_READY,
            mk_res(STAT_NOT_FOUND, 5'd0, 1'b1, 16'h0, 32'd1, 6'd1, 32'd0, 1'b0, 1'b0, 16'h0)));
        script_rows.push_back(golden(OP_REAP, 16'hFFFF, TS_UNUSED,
            mk_res(STAT_NOT_FOUND, 5'd0, 1'b1, 16'h0, 32'd1, 6'd1, 32'd0, 1'b0, 1'b0, 16'h0)));
        script_rows.push_back(golden(OP_SPAWN, 16'hFFFF, TS_UNUSED,
            mk_res(STAT_OK, 5'd1, 1'b1, 16'h0, 32'd1, 6'd2, 32'd0, 1'b0, 1'b0, 16'h0)));
        script_rows.push_back(plain(OP_SPAWN, 16'h0001, 3'd7));
        // slice runs out on the third tick: round-robin switch
        script_rows.push_back(plain(OP_TICK, 16'h0000, TS_UNUSED));
        script_rows.push_back(plain(OP_TICK, 16'h5A5A, TS_RUNNING));
        script_rows.push_back(plain(OP_TICK, 16'hA5A5, 3'd5));
        // run another task: the running one is demoted
        script_rows.push_back(plain(OP_SET, 16'h0001, TS_RUNNING));
        // undefined state leaves the slot alone
        script_rows.push_back(plain(OP_SET, 16'h0001, 3'd7));
        script_rows.push_back(plain(OP_SET, 16'hFFFF, TS_BLOCKED));
        script_rows.push_back(plain(OP_TICK, 16'hFFFF, 3'd6));
        script_rows.push_back(plain(OP_SET, 16'hFFFF, TS_ZOMBIE));
        // spawn reuses the zombie slot and counts it again
        script_rows.push_back(plain(OP_SPAWN, 16'h00AA, TS_BLOCKED));
        // reap of current falls back to id 0, then to no current at all
        script_rows.push_back(plain(OP_REAP, 16'h0001, TS_ZOMBIE));
        script_rows.push_back(plain(OP_REAP, 16'h0000, TS_READY));
        script_rows.push_back(plain(OP_TICK, 16'h8001, TS_RUNNING));
        script_rows.push_back(plain(OP_SET, 16'h00AA, TS_RUNNING));
        // current task left in a non-running state
        script_rows.push_back(plain(OP_SET, 16'h00AA, TS_UNUSED));
        script_rows.push_back(plain(OP_SPAWN, 16'h0000, 3'd6));
        script_rows.push_back(plain(OP_TICK, 16'h7FFF, TS_ZOMBIE));
        script_rows.push_back(plain(OP_SPAWN, 16'h8000, TS_ZOMBIE));
        script_rows.push_back(plain(OP_REAP, 16'h00AA, 3'd5));
        script_rows.push_back(plain(OP_TICK, 16'h0000, TS_UNUSED));
    endfunction

    // idle length: mostly none or short, now and then a long one
    function automatic int pause_len();
        int r;
        if (!pace_on) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // id of some task in the table, random when the table is empty
    function automatic logic [15:0] live_pid();
        int start;
        int hit;
        int idx;
        start = $urandom_range(NSLOT - 1);
        hit   = -1;
        for (int n = 0; n < NSLOT; n++) begin
            idx = (start + n) % NSLOT;
            if (hit < 0 && tbl_st[idx] != TS_UNUSED) hit = idx;
        end
        if (hit < 0) return 16'($urandom);
        return tbl_id[hit];
    endfunction

    function automatic logic [15:0] target_pid();
        int r;
        r = $urandom_range(99);
        if (r < 80) return live_pid();
        if (r < 85) return 16'h0000;
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] spawn_pid();
        int r;
        r = $urandom_range(99);
        if (r < 45) return 16'($urandom);
        if (r < 85) return 16'($urandom_range(7));
        return 16'hFFFF;
    endfunction

    function automatic logic [2:0] any_state();
        if ($urandom_range(9) != 0) return 3'($urandom_range(TS_ZOMBIE));
        return 3'($urandom_range(TS_ZOMBIE + 1, 7));
    endfunction

    task automatic log_miss(input string msg);
        miss_cnt++;
        if (miss_cnt <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Input channel: hold valid and payload until the transfer, then
    // record what the block owes for it.
    // ------------------------------------------------------------------
    task automatic offer(input rrts_in_t op, input logic gold_ok, input rrts_out_t gold);
        int        gap;
        rrts_out_t owed;
        gap = pause_len();
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= op;
        do @(posedge aclk); while (!s_ready);
        owed = sched_apply(op);
        pending_results.push_back(gold_ok ? gold : owed);
    endtask

    // drop valid and wait for every owed result, leaving the block idle
    task automatic drain();
        @(negedge aclk) s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (4) @(negedge aclk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic cfg_write(input logic [7:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SLICE_ADDR;
        pwdata  <= {{(PDATA_W - 8){1'b0}}, v};
        @(negedge aclk) penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        slice_limit = v;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // APB read of the slice register, checked against the shadow copy
    task automatic cfg_check();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= SLICE_ADDR;
        @(negedge aclk) penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[7:0] !== slice_limit)
            log_miss($sformatf("slice register read %0h, want %0h", prdata[7:0], slice_limit));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic new_slice(input logic [7:0] v);
        drain();
        cfg_write(v);
        cfg_check();
    endtask

    // Random phase. Most traffic targets ids that are in the table so set
    // state and reap hit; churn (zombie then spawn) pushes the used count up,
    // tick bursts run out slices, handoffs force demotions.
    task automatic run_random(input int n_items, input int mix);
        int          sent;
        int          roll;
        int          len;
        int          w_spawn;
        int          w_set;
        int          w_reap;
        int          p_churn;
        int          p_burst;
        int          p_hand;
        logic [1:0]  opc;
        logic [15:0] who;
        case (mix)
            MIX_FILL: begin
                w_spawn = 60; w_set = 15; w_reap = 5;
                p_churn = 5;  p_burst = 3; p_hand = 5;
            end
            MIX_CHURN: begin
                w_spawn = 20; w_set = 20; w_reap = 5;
                p_churn = 45; p_burst = 5; p_hand = 5;
            end
            MIX_DRAIN: begin
                w_spawn = 15; w_set = 25; w_reap = 40;
                p_churn = 3;  p_burst = 5; p_hand = 10;
            end
            default: begin
                w_spawn = 25; w_set = 30; w_reap = 15;
                p_churn = 5;  p_burst = 5; p_hand = 10;
            end
        endcase
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(99);
            if (roll < p_churn) begin
                offer(mk_op(OP_SET, live_pid(), TS_ZOMBIE), 1'b0, '0);
                offer(mk_op(OP_SPAWN, spawn_pid(), any_state()), 1'b0, '0);
                sent += 2;
            end else if (roll < p_churn + p_burst) begin
                // rarely long enough to pin the slice counter at its top
                len = ($urandom_range(19) == 0) ? 300 : $urandom_range(2, 30);
                repeat (len) offer(mk_op(OP_TICK, 16'($urandom), any_state()), 1'b0, '0);
                sent += len;
            end else if (roll < p_churn + p_burst + p_hand) begin
                offer(mk_op(OP_SET, live_pid(), TS_RUNNING), 1'b0, '0);
                offer(mk_op(OP_TICK, 16'($urandom), any_state()), 1'b0, '0);
                sent += 2;
            end else begin
                roll = $urandom_range(99);
                if (roll < w_spawn)                      opc = OP_SPAWN;
                else if (roll < w_spawn + w_set)         opc = OP_SET;
                else if (roll < w_spawn + w_set + w_reap) opc = OP_REAP;
                else                                     opc = OP_TICK;
                if ($urandom_range(19) == 0)  who = 16'($urandom);
                else if (opc == OP_SPAWN)     who = spawn_pid();
                else                          who = target_pid();
                offer(mk_op(opc, who, any_state()), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Clock and cycle watchdog
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("round_robin_task_table_scheduler verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result channel: random stalls at the falling edge; a requested hold
    // keeps ready low long enough for the block to back up its input.
    // ------------------------------------------------------------------
    initial begin
        m_ready     = 1'b0;
        stall_left  = 0;
        holds_taken = 0;
        forever begin
            @(negedge aclk);
            if (hold_asks != holds_taken) begin
                holds_taken = hold_asks;
                stall_left  = HOLD_CYCLES;
            end
            if (stall_left == 0) stall_left = pause_len();
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Check each result transfer against the oldest owed result.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            result_cnt++;
            if (pending_results.size() == 0) begin
                log_miss($sformatf("result %0d arrived with nothing owed: %p",
                                   result_cnt, m_data));
            end else begin
                want = pending_results.pop_front();
                diff = "";
                if (m_data.status !== want.status)
                    diff = {diff, $sformatf(" status %0d/%0d", m_data.status, want.status)};
                if (m_data.slot !== want.slot)
                    diff = {diff, $sformatf(" slot %0d/%0d", m_data.slot, want.slot)};
                if (m_data.current_valid !== want.current_valid)
                    diff = {diff, $sformatf(" current_valid %0b/%0b",
                                            m_data.current_valid, want.current_valid)};
                if (m_data.current_pid !== want.current_pid)
                    diff = {diff, $sformatf(" current_pid %0h/%0h",
                                            m_data.current_pid, want.current_pid)};
                if (m_data.current_runtime !== want.current_runtime)
                    diff = {diff, $sformatf(" current_runtime %0d/%0d",
                                            m_data.current_runtime, want.current_runtime)};
                if (m_data.task_count !== want.task_count)
                    diff = {diff, $sformatf(" task_count %0d/%0d",
                                            m_data.task_count, want.task_count)};
                if (m_data.switch_count !== want.switch_count)
                    diff = {diff, $sformatf(" switch_count %0d/%0d",
                                            m_data.switch_count, want.switch_count)};
                if (m_data.switched !== want.switched)
                    diff = {diff, $sformatf(" switched %0b/%0b", m_data.switched, want.switched)};
                if (m_data.demoted_valid !== want.demoted_valid)
                    diff = {diff, $sformatf(" demoted_valid %0b/%0b",
                                            m_data.demoted_valid, want.demoted_valid)};
                if (m_data.demoted_pid !== want.demoted_pid)
                    diff = {diff, $sformatf(" demoted_pid %0h/%0h",
                                            m_data.demoted_pid, want.demoted_pid)};
                if (diff.len() != 0)
                    log_miss($sformatf("result %0d mismatch (got/want):%s", result_cnt, diff));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        miss_cnt  = 0;
        result_cnt = 0;
        cycle_cnt = 0;
        hold_asks = 0;
        pace_on   = 1'b1;
        sched_reset();
        load_script();

        // synchronous reset, released at a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // slice register must read its reset value before any write
        cfg_check();
        foreach (script_rows[i])
            offer(script_rows[i].op, script_rows[i].gold_ok, script_rows[i].gold);
        run_random(250, MIX_BALANCED);

        // one-tick slice; mostly spawns so the table fills up
        new_slice(8'd1);
        run_random(250, MIX_FILL);

        // longest slice; churn drives the used count to its ceiling
        new_slice(8'd255);
        run_random(250, MIX_CHURN);

        // zero slice: every tick tries a switch; run without idling
        new_slice(8'd0);
        pace_on = 1'b0;
        run_random(250, MIX_BALANCED);
        pace_on = 1'b1;

        new_slice(8'd2);
        run_random(250, MIX_DRAIN);

        // hold the result side off while operations keep coming
        new_slice(8'($urandom_range(3, 20)));
        hold_asks++;
        run_random(250, MIX_BALANCED);

        new_slice(8'd3);
        run_random(250, MIX_FILL);

        new_slice(8'd7);
        run_random(250, MIX_DRAIN);

        // wait out the last results, then watch for strays
        drain();
        repeat (100) @(posedge aclk);
        if (miss_cnt == 0) begin
            $display("round_robin_task_table_scheduler verification clean");
        end else begin
            $display("round_robin_task_table_scheduler verification failed");
        end
        $finish;
    end

endmodule
